@@ hdl/sfc_pkg.sv @@
package sfc_pkg;

  // Input mode codes
  localparam logic [1:0] MODE_LOAD_WORLD = 2'd0;
  localparam logic [1:0] MODE_LOAD_LOCAL = 2'd1;
  localparam logic [1:0] MODE_TEST_WORLD = 2'd2;
  localparam logic [1:0] MODE_TEST_LOCAL = 2'd3;

  localparam int COEF_W = 32;
  localparam int FRAC_W = 16;
  localparam int PROD_W = 2 * COEF_W;
  localparam int SUM_W  = PROD_W + 2;

  // One stored plane: a, b, c, d in Q16.16
  typedef struct packed {
    logic [COEF_W-1:0] a;
    logic [COEF_W-1:0] b;
    logic [COEF_W-1:0] c;
    logic [COEF_W-1:0] d;
  } plane_t;

  // Tag that travels with each plane through the evaluation pipeline
  typedef struct packed {
    logic valid;
    logic last;
  } tag_t;

  // Verdict for one plane
  typedef struct packed {
    logic valid;
    logic last;
    logic exceed;
  } eval_res_t;

endpackage

@@ hdl/sfc_plane_mem.sv @@
module sfc_plane_mem #(
  parameter int DEPTH = 12
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  sfc_pkg::plane_t            wr_data,
  input  logic                       rd_en,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output sfc_pkg::plane_t            rd_data
);

  sfc_pkg::plane_t mem [DEPTH];
  sfc_pkg::plane_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hdl/sfc_plane_eval.sv @@
module sfc_plane_eval (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sfc_pkg::tag_t                 tag_in,
  input  sfc_pkg::plane_t               plane,
  input  logic [sfc_pkg::COEF_W-1:0]    pos_x,
  input  logic [sfc_pkg::COEF_W-1:0]    pos_y,
  input  logic [sfc_pkg::COEF_W-1:0]    pos_z,
  input  logic [sfc_pkg::COEF_W-1:0]    rng,
  output sfc_pkg::eval_res_t            res
);

  localparam int PW = sfc_pkg::PROD_W;
  localparam int CW = sfc_pkg::COEF_W;
  localparam int SW = sfc_pkg::SUM_W;
  localparam int DW = CW + 1 + sfc_pkg::FRAC_W;

  // stage 1: products and offset difference
  logic signed [PW-1:0] px_r, py_r, pz_r;
  logic signed [CW:0]   dr_r;
  sfc_pkg::tag_t        tag1_r;
  // stage 2: partial sums
  logic signed [PW:0]   s1_r, s2_r;
  sfc_pkg::tag_t        tag2_r;
  // stage 3: verdict
  sfc_pkg::eval_res_t   res_r;

  logic [DW-1:0]        dsh;
  logic signed [SW-1:0] total;

  always_ff @(posedge clk) begin
    px_r <= $signed(plane.a) * $signed(pos_x);
    py_r <= $signed(plane.b) * $signed(pos_y);
    pz_r <= $signed(plane.c) * $signed(pos_z);
    dr_r <= $signed({plane.d[CW-1], plane.d}) - $signed({rng[CW-1], rng});
  end

  assign dsh = {dr_r, {sfc_pkg::FRAC_W{1'b0}}};

  always_ff @(posedge clk) begin
    s1_r <= $signed({px_r[PW-1], px_r}) + $signed({py_r[PW-1], py_r});
    s2_r <= $signed({pz_r[PW-1], pz_r}) + $signed({{(PW+1-DW){dsh[DW-1]}}, dsh});
  end

  assign total = $signed({s1_r[PW], s1_r}) + $signed({s2_r[PW], s2_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r       <= '0;
      tag2_r       <= '0;
      res_r        <= '0;
    end else begin
      tag1_r       <= tag_in;
      tag2_r       <= tag1_r;
      res_r.valid  <= tag2_r.valid;
      res_r.last   <= tag2_r.last;
      // strictly positive sum: plane exceeded
      res_r.exceed <= !total[SW-1] && (total != '0);
    end
  end

  assign res = res_r;

endmodule

@@ hdl/sphere_frustum_cull_test.sv @@
// Sphere / frustum cull test.
// Holds two sets of PLANE_COUNT planes (world and local), each plane a, b, c,
// d in Q16.16, in one plane-wide memory. Issue a word with start while busy
// is low; the word is taken at that clock edge.
//   mode 0/1: load plane in_plane_index of the world/local set. Indexes at or
//             above PLANE_COUNT write nothing. The acknowledge (out_was_test
//             low, out_inside_res low) strobes on the next cycle; busy stays
//             low, so loads can go every cycle.
//   mode 2/3: test the point (in_pos_x, in_pos_y, in_pos_z) against every
//             plane of the world/local set; the point is outside if any
//             a*x+b*y+c*z+d is strictly above in_range. The sum is exact.
// A test reads one plane per cycle from the memory and passes each one
// through the read, multiply, add and compare pipeline stages; out_strobe
// rises and busy drops in the same cycle, once the last plane's verdict is
// in, and only then is a new word accepted.
// out_strobe lasts exactly one cycle; the receiver cannot stall it.
// Reset clears the control state only; plane contents are undefined until
// loaded, and testing an unloaded plane gives an arbitrary verdict.
module sphere_frustum_cull_test #(
  parameter int PLANE_COUNT = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [2:0]  in_plane_index,
  input  logic [31:0] in_plane_a,
  input  logic [31:0] in_plane_b,
  input  logic [31:0] in_plane_c,
  input  logic [31:0] in_plane_d,
  input  logic [31:0] in_pos_x,
  input  logic [31:0] in_pos_y,
  input  logic [31:0] in_pos_z,
  input  logic [31:0] in_range,
  output logic        out_strobe,
  output logic        out_inside_res,
  output logic        out_was_test
);

  localparam int DEPTH  = 2 * PLANE_COUNT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int PIDX_W = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;

  logic accept, is_test, idx_ok;
  logic mem_wr_en;
  logic [ADDR_W-1:0] set_base, wr_addr, rd_addr;
  sfc_pkg::plane_t wr_plane, rd_plane;

  // control
  logic busy_r, busy_nxt;
  logic issuing_r, issuing_nxt;
  logic set_r;
  logic [PIDX_W-1:0] cnt_r, cnt_nxt;
  logic issue_last;
  sfc_pkg::tag_t rd_tag_r;
  logic flag_r, flag_nxt;
  logic out_strobe_r, out_strobe_nxt;
  logic out_inside_r, out_inside_nxt;
  logic out_test_r, out_test_nxt;

  // held test operands
  logic [31:0] x_r, y_r, z_r, rng_r;

  sfc_pkg::eval_res_t ev;

  assign accept  = start && !busy_r;
  assign is_test = (in_mode == sfc_pkg::MODE_TEST_WORLD) ||
                   (in_mode == sfc_pkg::MODE_TEST_LOCAL);
  assign idx_ok  = 32'(in_plane_index) < 32'(PLANE_COUNT);

  // load: write the whole plane in the accept cycle
  assign mem_wr_en = accept && !is_test && idx_ok;
  assign wr_addr   = (in_mode[0] ? ADDR_W'(PLANE_COUNT) : '0) + ADDR_W'(in_plane_index);
  assign wr_plane  = '{a: in_plane_a, b: in_plane_b, c: in_plane_c, d: in_plane_d};

  // test: sweep the chosen set one plane a cycle
  assign set_base   = set_r ? ADDR_W'(PLANE_COUNT) : '0;
  assign rd_addr    = set_base + ADDR_W'(cnt_r);
  assign issue_last = (cnt_r == PIDX_W'(PLANE_COUNT - 1));

  sfc_plane_mem #(
    .DEPTH(DEPTH)
  ) u_mem (
    .clk    (clk),
    .wr_en  (mem_wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_plane),
    .rd_en  (issuing_r),
    .rd_addr(rd_addr),
    .rd_data(rd_plane)
  );

  sfc_plane_eval u_eval (
    .clk   (clk),
    .rst_n (rst_n),
    .tag_in(rd_tag_r),
    .plane (rd_plane),
    .pos_x (x_r),
    .pos_y (y_r),
    .pos_z (z_r),
    .rng   (rng_r),
    .res   (ev)
  );

  always_comb begin
    busy_nxt       = busy_r;
    issuing_nxt    = issuing_r;
    cnt_nxt        = cnt_r;
    flag_nxt       = flag_r;
    out_strobe_nxt = 1'b0;
    out_inside_nxt = out_inside_r;
    out_test_nxt   = out_test_r;

    // advance the read sweep
    if (issuing_r) begin
      cnt_nxt = cnt_r + PIDX_W'(1);
      if (issue_last) begin
        issuing_nxt = 1'b0;
      end
    end

    // collect plane verdicts; emit on the last one
    if (ev.valid) begin
      flag_nxt = flag_r | ev.exceed;
      if (ev.last) begin
        out_strobe_nxt = 1'b1;
        out_inside_nxt = !(flag_r | ev.exceed);
        out_test_nxt   = 1'b1;
        busy_nxt       = 1'b0;
      end
    end

    if (accept) begin
      if (is_test) begin
        busy_nxt    = 1'b1;
        issuing_nxt = 1'b1;
        cnt_nxt     = '0;
        flag_nxt    = 1'b0;
      end else begin
        out_strobe_nxt = 1'b1;
        out_inside_nxt = 1'b0;
        out_test_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      issuing_r    <= 1'b0;
      cnt_r        <= '0;
      flag_r       <= 1'b0;
      rd_tag_r     <= '0;
      out_strobe_r <= 1'b0;
      out_inside_r <= 1'b0;
      out_test_r   <= 1'b0;
    end else begin
      busy_r         <= busy_nxt;
      issuing_r      <= issuing_nxt;
      cnt_r          <= cnt_nxt;
      flag_r         <= flag_nxt;
      rd_tag_r.valid <= issuing_r;
      rd_tag_r.last  <= issuing_r && issue_last;
      out_strobe_r   <= out_strobe_nxt;
      out_inside_r   <= out_inside_nxt;
      out_test_r     <= out_test_nxt;
    end
  end

  // hold the test operands for the whole sweep
  always_ff @(posedge clk) begin
    if (accept && is_test) begin
      set_r <= in_mode[0];
      x_r   <= in_pos_x;
      y_r   <= in_pos_y;
      z_r   <= in_pos_z;
      rng_r <= in_range;
    end
  end

  assign busy           = busy_r;
  assign out_strobe     = out_strobe_r;
  assign out_inside_res = out_inside_r;
  assign out_was_test   = out_test_r;

  // a load is acknowledged on the very next cycle
  a_load_ack: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_mode[1]) |=> (out_strobe && !out_was_test && !out_inside_res))
    else $error("load word not acknowledged next cycle");

  // the read sweep only runs inside a busy test
  a_sweep_busy: assert property (@(posedge clk) disable iff (!rst_n)
    issuing_r |-> busy_r)
    else $error("plane read issued while not busy");

  // a test result always ends the busy period
  a_test_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_was_test) |-> (!busy && $past(busy)))
    else $error("test result without closing busy");

  // no plane verdict arrives outside a test
  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ev.valid |-> busy_r)
    else $error("plane verdict while idle");

endmodule
